### hw/rtl/bmhq_pkg.sv
// bmhq_pkg: sizes, codes and shared types of the binary max-heap queue
// no dependencies; imported by bmhq_ram, bmhq_cmp, binary_max_heap_queue_core and the testbench
package bmhq_pkg;

	localparam int DEPTH   = 1024;
	localparam int IDX_W   = $clog2(DEPTH);
	localparam int CNT_W   = $clog2(DEPTH + 1);
	localparam int CHILD_W = IDX_W + 2;
	localparam int KEY_W   = 64;
	localparam int ENTRY_W = 11;
	localparam int STAT_W  = 2;

	localparam logic FUNC_INSERT = 1'b0;
	localparam logic FUNC_REMOVE = 1'b1;

	localparam logic [STAT_W-1:0] STAT_DONE  = 2'd0;
	localparam logic [STAT_W-1:0] STAT_FULL  = 2'd1;
	localparam logic [STAT_W-1:0] STAT_EMPTY = 2'd2;

	typedef logic signed [KEY_W-1:0] key_t;
	typedef logic [IDX_W-1:0] idx_t;
	typedef logic [CNT_W-1:0] cnt_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_UP_RD,
		S_UP_CMP,
		S_DN_LOAD,
		S_DN_RD,
		S_DN_CMP,
		S_DONE
	} state_t;

	// flags from the shared compare unit
	typedef struct packed {
		logic pick_right;
		logic best_gt_key;
		logic key_gt_best;
	} cmp_res_t;

endpackage

### hw/rtl/bmhq_ram.sv
// bmhq_ram: heap storage, one write port and two registered read ports
// depends on bmhq_pkg
module bmhq_ram (
	input  logic           clk,
	input  logic           we,
	input  bmhq_pkg::idx_t waddr,
	input  bmhq_pkg::key_t wdata,
	input  bmhq_pkg::idx_t raddr0,
	input  bmhq_pkg::idx_t raddr1,
	output bmhq_pkg::key_t rdata0,
	output bmhq_pkg::key_t rdata1
);
	import bmhq_pkg::*;

	key_t mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		rdata0 <= mem[raddr0];
		rdata1 <= mem[raddr1];
	end

endmodule

### hw/rtl/bmhq_cmp.sv
// bmhq_cmp: shared signed compare unit, picks the larger child and
// compares it with the moving key; depends on bmhq_pkg
module bmhq_cmp (
	input  bmhq_pkg::key_t     key,
	input  bmhq_pkg::key_t     left,
	input  bmhq_pkg::key_t     right,
	input  logic               right_en,
	output bmhq_pkg::key_t     best,
	output bmhq_pkg::cmp_res_t res
);
	import bmhq_pkg::*;

	// equal children keep the left one
	assign res.pick_right  = right_en && (right > left);
	assign best            = res.pick_right ? right : left;
	assign res.best_gt_key = best > key;
	assign res.key_gt_best = key > best;

endmodule

### hw/rtl/binary_max_heap_queue_core.sv
// binary_max_heap_queue_core: bounded max-heap priority queue, 1024 signed keys
// insert: a read state and a compare state per level sifted up, then the done state
// remove: a load state, then a read state and a compare state per level sifted down, then the done state
// one word at a time; each level is one read and compare on the shared unit
// reset clears the count and the output valid; the heap memory is not cleared
module binary_max_heap_queue_core (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	output logic                           in_ready,
	input  logic                           func,
	input  logic signed [63:0]             value,
	output logic                           out_valid,
	input  logic                           out_ready,
	output logic signed [63:0]             removed_value,
	output logic signed [63:0]             top_value,
	output logic [bmhq_pkg::ENTRY_W-1:0]   entry_count,
	output logic [bmhq_pkg::STAT_W-1:0]    status
);
	import bmhq_pkg::*;

	state_t             state_q, state_d;
	cnt_t               count_q;
	idx_t               pos_q;
	idx_t               parent_q;
	key_t               key_q;
	key_t               root_q;
	key_t               removed_q;
	logic [STAT_W-1:0]  stat_q;

	logic               mem_we;
	idx_t               mem_waddr;
	key_t               mem_wdata;
	idx_t               mem_ra0, mem_ra1;
	key_t               mem_rd0, mem_rd1;

	key_t               best;
	cmp_res_t           cmp;

	logic [CHILD_W-1:0] lchild, rchild;
	logic               l_in, r_in;
	idx_t               best_idx;
	idx_t               parent_idx;
	logic               out_free;
	logic               in_acc;

	bmhq_ram u_ram (
		.clk    (clk),
		.we     (mem_we),
		.waddr  (mem_waddr),
		.wdata  (mem_wdata),
		.raddr0 (mem_ra0),
		.raddr1 (mem_ra1),
		.rdata0 (mem_rd0),
		.rdata1 (mem_rd1)
	);

	bmhq_cmp u_cmp (
		.key      (key_q),
		.left     (mem_rd0),
		.right    (mem_rd1),
		.right_en ((state_q == S_DN_CMP) && r_in),
		.best     (best),
		.res      (cmp)
	);

	assign lchild     = {1'b0, pos_q, 1'b1};
	assign rchild     = lchild + CHILD_W'(1);
	assign l_in       = lchild < CHILD_W'(count_q);
	assign r_in       = rchild < CHILD_W'(count_q);
	assign best_idx   = cmp.pick_right ? rchild[IDX_W-1:0] : lchild[IDX_W-1:0];
	assign parent_idx = (pos_q - idx_t'(1)) >> 1;
	assign out_free   = !out_valid || out_ready;
	assign in_ready   = (state_q == S_IDLE);
	assign in_acc     = in_valid && in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		mem_we    = 1'b0;
		mem_waddr = pos_q;
		mem_wdata = key_q;
		mem_ra0   = parent_idx;
		mem_ra1   = rchild[IDX_W-1:0];
		unique case (state_q)
			S_IDLE: begin
				// read the last entry in case this is a remove
				mem_ra0 = idx_t'(count_q - cnt_t'(1));
				if (in_acc) begin
					if (func == FUNC_INSERT) begin
						state_d = (count_q == cnt_t'(DEPTH)) ? S_DONE : S_UP_RD;
					end else begin
						state_d = (count_q == '0) ? S_DONE : S_DN_LOAD;
					end
				end
			end
			S_UP_RD: begin
				if (pos_q == '0) begin
					mem_we  = 1'b1;
					state_d = S_DONE;
				end else begin
					state_d = S_UP_CMP;
				end
			end
			S_UP_CMP: begin
				mem_we = 1'b1;
				if (cmp.key_gt_best) begin
					mem_wdata = mem_rd0;
					state_d   = S_UP_RD;
				end else begin
					state_d = S_DONE;
				end
			end
			S_DN_LOAD: begin
				state_d = (count_q == '0) ? S_DONE : S_DN_RD;
			end
			S_DN_RD: begin
				mem_ra0 = lchild[IDX_W-1:0];
				if (!l_in) begin
					mem_we  = 1'b1;
					state_d = S_DONE;
				end else begin
					state_d = S_DN_CMP;
				end
			end
			S_DN_CMP: begin
				mem_we = 1'b1;
				if (cmp.best_gt_key) begin
					mem_wdata = best;
					state_d   = S_DN_RD;
				end else begin
					state_d = S_DONE;
				end
			end
			S_DONE: begin
				if (out_free) begin
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (in_acc) begin
			if (func == FUNC_INSERT && count_q != cnt_t'(DEPTH)) begin
				count_q <= count_q + cnt_t'(1);
			end else if (func == FUNC_REMOVE && count_q != '0) begin
				count_q <= count_q - cnt_t'(1);
			end
		end
	end

	// datapath registers of the sift
	always_ff @(posedge clk) begin
		if (mem_we && mem_waddr == '0) begin
			root_q <= mem_wdata;
		end
		case (state_q)
			S_IDLE: begin
				if (in_acc) begin
					key_q <= value;
					pos_q <= idx_t'(count_q);
					if (func == FUNC_INSERT) begin
						removed_q <= '0;
						stat_q    <= (count_q == cnt_t'(DEPTH)) ? STAT_FULL : STAT_DONE;
					end else if (count_q == '0) begin
						removed_q <= '0;
						stat_q    <= STAT_EMPTY;
					end else begin
						removed_q <= root_q;
						stat_q    <= STAT_DONE;
					end
				end
			end
			S_UP_RD: begin
				parent_q <= parent_idx;
			end
			S_UP_CMP: begin
				if (cmp.key_gt_best) begin
					pos_q <= parent_q;
				end
			end
			S_DN_LOAD: begin
				key_q <= mem_rd0;
				pos_q <= '0;
			end
			S_DN_CMP: begin
				if (cmp.best_gt_key) begin
					pos_q <= best_idx;
				end
			end
			default: begin
			end
		endcase
	end

	// output word register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (state_q == S_DONE && out_free) begin
			out_valid <= 1'b1;
		end else if (out_ready) begin
			out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_DONE && out_free) begin
			removed_value <= removed_q;
			top_value     <= (count_q != '0) ? root_q : '0;
			entry_count   <= ENTRY_W'(count_q);
			status        <= stat_q;
		end
	end

endmodule

### test/tb_binary_max_heap_queue_core.sv
`timescale 1ns / 1ps
// tb_binary_max_heap_queue_core: self-checking bench for the max-heap priority queue core
// keeps its own heap model in a scoreboard class; depends on bmhq_pkg and the core only
module tb_binary_max_heap_queue_core;
	import bmhq_pkg::*;

	typedef struct packed {
		key_t                removed;
		key_t                top;
		logic [ENTRY_W-1:0]  count;
		logic [STAT_W-1:0]   status;
	} heap_result_t;

	class heap_scoreboard;
		key_t         heap_mem [DEPTH];
		int unsigned  fill;
		heap_result_t expected_q [$];
		int           mismatches;
		int           words_in;
		int           results_seen;
		int           full_drops;
		int           empty_removes;
		int           peak;

		function new();
			fill = 0;
			mismatches = 0;
			words_in = 0;
			results_seen = 0;
			full_drops = 0;
			empty_removes = 0;
			peak = 0;
		endfunction

		function int pending();
			return expected_q.size();
		endfunction

		// apply one accepted word to the local heap and queue the result it should give
		function void note_word(logic f, key_t v);
			heap_result_t r;
			int unsigned  pos;
			int unsigned  lc;
			int unsigned  rc;
			int unsigned  best;
			key_t         t;
			bit           moving;
			r.removed = '0;
			r.status = STAT_DONE;
			words_in++;
			if (f == FUNC_INSERT) begin
				if (fill >= DEPTH) begin
					r.status = STAT_FULL;
					full_drops++;
				end else begin
					pos = fill;
					heap_mem[pos] = v;
					fill++;
					// move up only while strictly larger than the parent
					while (pos > 0 && heap_mem[pos] > heap_mem[(pos - 1) / 2]) begin
						t = heap_mem[pos];
						heap_mem[pos] = heap_mem[(pos - 1) / 2];
						heap_mem[(pos - 1) / 2] = t;
						pos = (pos - 1) / 2;
					end
				end
			end else begin
				if (fill == 0) begin
					r.status = STAT_EMPTY;
					empty_removes++;
				end else begin
					r.removed = heap_mem[0];
					fill--;
					heap_mem[0] = heap_mem[fill];
					pos = 0;
					moving = 1'b1;
					// left child wins a tie, and no swap with an equal child
					while (moving) begin
						lc = 2 * pos + 1;
						rc = 2 * pos + 2;
						best = pos;
						if (lc < fill && heap_mem[lc] > heap_mem[best])
							best = lc;
						if (rc < fill && heap_mem[rc] > heap_mem[best])
							best = rc;
						if (best == pos) begin
							moving = 1'b0;
						end else begin
							t = heap_mem[pos];
							heap_mem[pos] = heap_mem[best];
							heap_mem[best] = t;
							pos = best;
						end
					end
				end
			end
			if (fill > peak)
				peak = fill;
			r.top = (fill > 0) ? heap_mem[0] : '0;
			r.count = ENTRY_W'(fill);
			expected_q.push_back(r);
		endfunction

		function void check_word(key_t rem, key_t top, logic [ENTRY_W-1:0] cnt,
				logic [STAT_W-1:0] st);
			heap_result_t e;
			results_seen++;
			if (expected_q.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result word: rem=%0d top=%0d cnt=%0d st=%0d",
						rem, top, cnt, st);
				return;
			end
			e = expected_q.pop_front();
			if (e.removed !== rem || e.top !== top || e.count !== cnt || e.status !== st) begin
				mismatches++;
				if (mismatches <= 10)
					$display({"mismatch at result %0d: exp rem=%0d top=%0d cnt=%0d st=%0d,",
						" got rem=%0d top=%0d cnt=%0d st=%0d"},
						results_seen, e.removed, e.top, e.count, e.status,
						rem, top, cnt, st);
			end
		endfunction
	endclass

	logic                 clk;
	logic                 arst_n = 1'b0;
	logic                 in_valid = 1'b0;
	logic                 in_ready;
	logic                 func = FUNC_INSERT;
	key_t                 value = '0;
	logic                 out_valid;
	logic                 out_ready = 1'b0;
	key_t                 removed_value;
	key_t                 top_value;
	logic [ENTRY_W-1:0]   entry_count;
	logic [STAT_W-1:0]    status;

	heap_scoreboard sb;
	bit tx_steady = 1'b0;
	bit rx_steady = 1'b0;
	int rx_hold = 0;

	binary_max_heap_queue_core dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.func          (func),
		.value         (value),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.removed_value (removed_value),
		.top_value     (top_value),
		.entry_count   (entry_count),
		.status        (status)
	);

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	// result side: check on accept, then draw a stall for the next word
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			sb.check_word(removed_value, top_value, entry_count, status);
			if ($urandom_range(0, 39) == 0)
				rx_steady = !rx_steady;
			rx_hold = rx_steady ? 0 : $urandom_range(0, 16);
		end
	end

	always @(negedge clk) begin
		if (!arst_n || rx_hold > 0) begin
			out_ready <= 1'b0;
			if (arst_n)
				rx_hold = rx_hold - 1;
		end else begin
			out_ready <= 1'b1;
		end
	end

	function automatic key_t rand_key();
		int k;
		k = $urandom_range(0, 3);
		case (k)
			0: return key_t'($urandom_range(0, 16)) - key_t'(8);
			1: begin
				case ($urandom_range(0, 3))
					0: return {1'b1, 63'd0} + key_t'($urandom_range(0, 3));
					1: return {1'b0, {63{1'b1}}} - key_t'($urandom_range(0, 3));
					2: return key_t'(0);
					default: return -key_t'(1);
				endcase
			end
			default: return {$urandom, $urandom};
		endcase
	endfunction

	task automatic send_word(input logic f, input key_t v);
		int gap;
		if ($urandom_range(0, 49) == 0)
			tx_steady = !tx_steady;
		gap = tx_steady ? 0 : $urandom_range(0, 16);
		@(negedge clk);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid <= 1'b1;
		func <= f;
		value <= v;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		sb.note_word(f, v);
	endtask

	task automatic run_mix(input int n, input int insert_pct);
		for (int i = 0; i < n; i++)
			send_word(($urandom_range(0, 99) < insert_pct) ? FUNC_INSERT : FUNC_REMOVE,
				rand_key());
	endtask

	// drop the valid so the last accepted word is not taken again
	task automatic wait_drained();
		@(negedge clk);
		in_valid <= 1'b0;
		while (sb.pending() != 0)
			@(posedge clk);
	endtask

	initial begin
		#10_000_000;
		$display("TB_ERROR");
		$finish;
	end

	initial begin
		sb = new();
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// directed: empty remove, extreme keys, duplicates, drain past empty
		send_word(FUNC_REMOVE, {$urandom, $urandom});
		send_word(FUNC_INSERT, {1'b1, 63'd0});
		send_word(FUNC_INSERT, {1'b0, {63{1'b1}}});
		send_word(FUNC_INSERT, key_t'(0));
		send_word(FUNC_INSERT, -key_t'(1));
		send_word(FUNC_INSERT, {1'b0, {63{1'b1}}});
		send_word(FUNC_INSERT, {1'b1, 63'd0});
		send_word(FUNC_INSERT, key_t'(1));
		send_word(FUNC_INSERT, 64'h5555_5555_5555_5555);
		send_word(FUNC_INSERT, 64'haaaa_aaaa_aaaa_aaaa);
		repeat (10) send_word(FUNC_REMOVE, {$urandom, $urandom});
		repeat (3) send_word(FUNC_INSERT, key_t'(7));
		send_word(FUNC_INSERT, key_t'(3));
		repeat (4) send_word(FUNC_REMOVE, '0);

		run_mix(60, 60);
		wait_drained();

		// fill to capacity, then push against the full heap
		while (sb.fill < DEPTH)
			send_word(FUNC_INSERT, rand_key());
		repeat (4) send_word(FUNC_INSERT, rand_key());
		run_mix(40, 70);

		// mostly removes from a deep heap
		run_mix(60, 20);

		wait_drained();
		repeat (60) @(posedge clk);

		$display("heap run: %0d words in, %0d results checked, peak %0d keys",
			sb.words_in, sb.results_seen, sb.peak);
		$display("covered %0d inserts dropped when full, %0d removes on empty, %0d mismatches",
			sb.full_drops, sb.empty_removes, sb.mismatches);
		if (sb.mismatches == 0 && sb.pending() == 0) begin
			$display("TB_OK");
		end else begin
			$display("TB_ERROR");
		end
		$finish;
	end

endmodule

### sim.f
hw/rtl/bmhq_pkg.sv
hw/rtl/bmhq_ram.sv
hw/rtl/bmhq_cmp.sv
hw/rtl/binary_max_heap_queue_core.sv
test/tb_binary_max_heap_queue_core.sv
